@@ design/ills_pkg.sv @@
// Shared types and constants for the indexed linked list store.
// No dependencies; imported by every design module.
`timescale 1ns / 1ps
`default_nettype none
package ills_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_POS  = 3'd1,
    KIND_DEL_HEAD = 3'd2,
    KIND_DEL_POS  = 3'd3,
    KIND_SEARCH   = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_WAIT, S_CHK, S_INS_B, S_DWAIT, S_DEL_B, S_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_STEP, OP_RANGE, OP_FULL, OP_MISS, OP_FOUND,
    OP_INS_HEAD, OP_INS_A, OP_INS_B, OP_DEL_HEAD, OP_DEL_A, OP_DEL_B, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_over;   // insert position beyond count
    logic              del_over;   // delete position at or beyond count
    logic              pos_zero;   // effective position is the head
    logic              at_prev;    // walk stands on the node before the position
    logic              at_end;     // walk has visited every entry
    logic              match;      // current node holds the searched value
    logic              full;
    logic              out_busy;   // result register occupied and stalled
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/ills_ctrl.sv @@
// Controller for the indexed linked list store: sequences walks and updates.
// Depends on ills_pkg; drives ills_dp through a command struct.
`timescale 1ns / 1ps
`default_nettype none
module ills_ctrl
  import ills_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;
  dp_op_t     chk_op;

  // Decide the action taken while checking the current node
  always_comb begin
    chk_op = OP_RANGE;
    case (stat.kind)
      KIND_INS_HEAD, KIND_INS_POS: begin
        if (stat.kind == KIND_INS_POS && stat.ins_over) chk_op = OP_RANGE;
        else if (stat.full) chk_op = OP_FULL;
        else if (stat.kind == KIND_INS_HEAD || stat.pos_zero) chk_op = OP_INS_HEAD;
        else if (stat.at_prev) chk_op = OP_INS_A;
        else chk_op = OP_STEP;
      end
      KIND_DEL_HEAD, KIND_DEL_POS: begin
        if (stat.del_over) chk_op = OP_RANGE;
        else if (stat.pos_zero) chk_op = OP_DEL_HEAD;
        else if (stat.at_prev) chk_op = OP_DEL_A;
        else chk_op = OP_STEP;
      end
      KIND_SEARCH: begin
        if (stat.at_end) chk_op = OP_MISS;
        else if (stat.match) chk_op = OP_FOUND;
        else chk_op = OP_STEP;
      end
      default: chk_op = OP_RANGE;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_CHK;
      S_CHK: begin
        case (chk_op)
          OP_STEP:  state_nxt = S_WAIT;
          OP_INS_A: state_nxt = S_INS_B;
          OP_DEL_A: state_nxt = S_DWAIT;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_INS_B: state_nxt = S_OUT;
      S_DWAIT: state_nxt = S_DEL_B;
      S_DEL_B: state_nxt = S_OUT;
      S_OUT:   if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_INIT:  cmd.op = OP_INIT;
      S_CHK:   cmd.op = chk_op;
      S_INS_B: cmd.op = OP_INS_B;
      S_DEL_B: cmd.op = OP_DEL_B;
      S_OUT:   if (!stat.out_busy) cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

@@ design/ills_dp.sv @@
// Datapath for the indexed linked list store: node memories, free-slot stack,
// list registers and the result register. Depends on ills_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ills_dp
  import ills_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CNT_W-1:0]  in_position,
  input  wire logic [VAL_W-1:0]  in_item_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_W-1:0]       out_found_position,
  output logic [CNT_W-1:0]       out_entry_count
);

  logic [VAL_W-1:0]  val_mem  [CAPACITY];
  logic [CNT_W-1:0]  link_mem [CAPACITY];
  logic [SLOT_W-1:0] free_mem [CAPACITY];

  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  head_r, count_r, top_r, low_r, cur_r, idx_r;
  logic [SLOT_W-1:0] prev_r, slot_r;
  logic [STAT_W-1:0] status_r;
  logic [CNT_W-1:0]  found_r;
  logic [VAL_W-1:0]  vrd_r;
  logic [CNT_W-1:0]  lrd_r;
  logic [SLOT_W-1:0] frd_r, fidx_r;
  logic              finit_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_found_r, out_count_r;

  logic [CNT_W-1:0]  pos_eff, fa, top_dn;
  logic [SLOT_W-1:0] pop_slot;

  assign pos_eff  = (kind_r == KIND_DEL_HEAD) ? '0 : pos_r;
  assign fa       = top_r - CNT_W'(1);
  assign top_dn   = top_r - CNT_W'(1);
  // Entries below the low-water mark were never overwritten: they still hold
  // their reset order, highest slot at the bottom
  assign pop_slot = finit_r ? (SLOT_W'(CAPACITY - 1) - fidx_r) : frd_r;

  // Status toward the controller
  always_comb begin
    stat.kind     = kind_r;
    stat.ins_over = pos_r > count_r;
    stat.del_over = pos_eff >= count_r;
    stat.pos_zero = pos_eff == '0;
    stat.at_prev  = idx_r == pos_eff - CNT_W'(1);
    stat.at_end   = idx_r == count_r;
    stat.match    = vrd_r == val_r;
    stat.full     = (top_r == '0) || (count_r >= CNT_W'(CAPACITY));
    stat.out_busy = out_valid_r && !out_ready;
  end

  // Node memories: one write, one registered read at the walk pointer
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INS_HEAD: begin
        val_mem[pop_slot]  <= val_r;
        link_mem[pop_slot] <= head_r;
      end
      OP_INS_A: begin
        val_mem[pop_slot]  <= val_r;
        link_mem[pop_slot] <= lrd_r;
      end
      OP_INS_B: link_mem[cur_r[SLOT_W-1:0]] <= {1'b0, slot_r};
      OP_DEL_B: link_mem[prev_r] <= lrd_r;
      default: ;
    endcase
    vrd_r <= val_mem[cur_r[SLOT_W-1:0]];
    lrd_r <= link_mem[cur_r[SLOT_W-1:0]];
  end

  // Free-slot stack: push on delete, registered read of the top entry
  always_ff @(posedge clk) begin
    if (top_r < CNT_W'(CAPACITY)) begin
      if (cmd.op == OP_DEL_HEAD) free_mem[top_r[SLOT_W-1:0]] <= cur_r[SLOT_W-1:0];
      if (cmd.op == OP_DEL_B)    free_mem[top_r[SLOT_W-1:0]] <= slot_r;
    end
    frd_r   <= free_mem[fa[SLOT_W-1:0]];
    fidx_r  <= fa[SLOT_W-1:0];
    finit_r <= fa < low_r;
  end

  // Request, walk and scratch registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r   <= in_kind;
        pos_r    <= in_position;
        val_r    <= in_item_value;
        status_r <= ST_RANGE;
        found_r  <= '1;
      end
      OP_INIT: begin
        cur_r <= head_r;
        idx_r <= '0;
      end
      OP_STEP: begin
        cur_r <= lrd_r;
        idx_r <= idx_r + CNT_W'(1);
      end
      OP_RANGE: status_r <= ST_RANGE;
      OP_FULL:  status_r <= ST_FULL;
      OP_MISS:  status_r <= ST_MISSING;
      OP_FOUND: begin
        status_r <= ST_DONE;
        found_r  <= idx_r;
      end
      OP_INS_HEAD, OP_INS_B, OP_DEL_HEAD, OP_DEL_B: status_r <= ST_DONE;
      OP_INS_A: slot_r <= pop_slot;
      OP_DEL_A: begin
        prev_r <= cur_r[SLOT_W-1:0];
        slot_r <= lrd_r[SLOT_W-1:0];
        cur_r  <= lrd_r;
      end
      default: ;
    endcase
    if (cmd.op == OP_OUT) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= count_r;
    end
  end

  // List head, count, stack top and low-water mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= CNT_W'(CAPACITY);
      count_r     <= '0;
      top_r       <= CNT_W'(CAPACITY);
      low_r       <= CNT_W'(CAPACITY);
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_INS_HEAD: begin
          head_r  <= {1'b0, pop_slot};
          top_r   <= top_dn;
          count_r <= count_r + CNT_W'(1);
          if (top_dn < low_r) low_r <= top_dn;
        end
        OP_INS_A: begin
          top_r <= top_dn;
          if (top_dn < low_r) low_r <= top_dn;
        end
        OP_INS_B: count_r <= count_r + CNT_W'(1);
        OP_DEL_HEAD: begin
          head_r  <= lrd_r;
          count_r <= count_r - CNT_W'(1);
          if (top_r < CNT_W'(CAPACITY)) top_r <= top_r + CNT_W'(1);
        end
        OP_DEL_B: begin
          count_r <= count_r - CNT_W'(1);
          if (top_r < CNT_W'(CAPACITY)) top_r <= top_r + CNT_W'(1);
        end
        default: ;
      endcase
      // Hold the result until the transaction completes
      if (cmd.op == OP_OUT)  out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;

endmodule
`default_nettype wire

@@ design/indexed_linked_list_store.sv @@
// Top level of the indexed linked list store: controller plus datapath.
// Depends on ills_pkg, ills_ctrl and ills_dp.
//
// Usage: one request per input transaction (kind, position, item_value) and
// exactly one result transaction (status, found_position, entry_count).
// Requests are handled one at a time; in_ready is high only while idle.
// Head inserts, head deletes and out-of-range requests need no walk.
// Positional inserts and deletes walk the links to the node before the
// position, one node per wait and check step (registered read of the link
// memory); a delete then reads the link of the removed node. A search walks
// from the head to the hit, or through every entry on a miss.
// The result register holds a finished result while out_ready is low; the
// block then waits with the next result until that transaction completes.
// Reset empties the list and frees all slots at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module indexed_linked_list_store
  import ills_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CNT_W-1:0]  in_position,
  input  wire logic [VAL_W-1:0]  in_item_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_W-1:0]       out_found_position,
  output logic [CNT_W-1:0]       out_entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ills_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ills_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

endmodule
`default_nettype wire

@@ design/ills_checker.sv @@
// Port-level checks for the indexed linked list store, bound to the top level.
// Depends on ills_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ills_checker
  import ills_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [CNT_W-1:0]  out_found_position,
  input wire logic [CNT_W-1:0]  out_entry_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_position) && $stable(out_entry_count))
    else $error("stalled result changed");

  // Drop any result after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A found position comes only with a done status
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_position != '1 |-> out_status == ST_DONE)
    else $error("found position without done status");

  // Full only when the list holds every slot
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("full status with free slots");

endmodule

bind indexed_linked_list_store ills_checker u_ills_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_found_position (out_found_position),
  .out_entry_count    (out_entry_count)
);
`default_nettype wire
